// ----- design/tlbp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlbp_pkg
// Shared types, codes and the counter step for the two-level predictor.
// ----------------------------------------------------------------------------
package tlbp_pkg;

    typedef logic [1:0] ctr_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIST,
        ST_UPDATE
    } state_t;

    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_UPDATE  = 1'b1;

    localparam ctr_t CTR_MIN       = 2'b00;
    localparam ctr_t CTR_MAX       = 2'd3;
    localparam ctr_t CTR_TAKEN_MIN = 2'd2;

    // Move one step toward the resolved outcome, saturating at both ends.
    function automatic ctr_t ctr_step(input ctr_t ctr, input logic taken);
        ctr_t res;
        res = ctr;
        if (taken)
        begin
            if (ctr != CTR_MAX)
            begin
                res = ctr + 2'd1;
            end
        end
        else
        begin
            if (ctr != CTR_MIN)
            begin
                res = ctr - 2'd1;
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- design/tlbp_pattern_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlbp_pattern_table
// Pattern history table: 2-bit counters, one write and one registered read.
// ----------------------------------------------------------------------------
module tlbp_pattern_table #(
    parameter int SLOT_BITS = 20
) (
    input  wire                     clk,
    input  wire                     rd_en,
    input  wire  [SLOT_BITS-1:0]    rd_addr,
    output tlbp_pkg::ctr_t          rd_ctr,
    input  wire                     wr_en,
    input  wire  [SLOT_BITS-1:0]    wr_addr,
    input  tlbp_pkg::ctr_t          wr_ctr
);

    localparam int DEPTH = 1 << SLOT_BITS;

    tlbp_pkg::ctr_t ctr_mem [DEPTH];
    tlbp_pkg::ctr_t rd_ctr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ctr_mem[wr_addr] <= wr_ctr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_ctr_reg <= ctr_mem[rd_addr];
        end
    end

    assign rd_ctr = rd_ctr_reg;

endmodule
`default_nettype wire

// ----- design/two_level_branch_predictor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_branch_predictor
// Per-address history, per-address pattern table (PAp) branch predictor.
// ----------------------------------------------------------------------------
// On each beat the history memory is read, its data then addresses the
// counter memory, and ST_UPDATE forms the prediction and writes both
// memories back on an update; one beat is in flight at a time.
// The result sits in an output register, so a new beat can be taken while
// the previous prediction waits. After reset a clearing pass zeroes both
// memories, one counter entry per cycle, over 2^(INDEX_BITS+HISTORY_BITS)
// entries (1,048,576 at the defaults); in_ready stays low until it ends.
// ----------------------------------------------------------------------------
module two_level_branch_predictor #(
    parameter int INDEX_BITS   = 10,
    parameter int HISTORY_BITS = 10,
    parameter int ADDRESS_BITS = 48
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire                     mode,
    input  wire  [ADDRESS_BITS-1:0] branch_address,
    input  wire                     outcome_taken,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic                    predicted_taken
);

    localparam int SLOT_BITS   = INDEX_BITS + HISTORY_BITS;
    localparam int HIST_DEPTH  = 1 << INDEX_BITS;

    tlbp_pkg::state_t          state_reg, state_next;
    logic [SLOT_BITS-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      pred_reg, pred_next;
    logic                      mode_reg;
    logic                      taken_reg;
    logic [INDEX_BITS-1:0]     entry_reg;

    logic [HISTORY_BITS-1:0]   hist_mem [HIST_DEPTH];
    logic [HISTORY_BITS-1:0]   hist_rd_reg;

    logic                      accept;
    logic [INDEX_BITS-1:0]     in_entry;
    logic                      hist_we;
    logic [INDEX_BITS-1:0]     hist_waddr;
    logic [HISTORY_BITS-1:0]   hist_wdata;
    logic                      ctr_re;
    logic [SLOT_BITS-1:0]      ctr_raddr;
    tlbp_pkg::ctr_t            ctr_rd;
    logic                      ctr_we;
    logic [SLOT_BITS-1:0]      ctr_waddr;
    tlbp_pkg::ctr_t            ctr_wdata;

    assign in_ready  = (state_reg == tlbp_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign in_entry  = branch_address[ADDRESS_BITS-1 -: INDEX_BITS];
    assign ctr_raddr = {entry_reg, hist_rd_reg};

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pred_next      = pred_reg;
        hist_we        = 1'b0;
        hist_waddr     = entry_reg;
        hist_wdata     = HISTORY_BITS'({hist_rd_reg, taken_reg});
        ctr_re         = 1'b0;
        ctr_we         = 1'b0;
        ctr_waddr      = ctr_raddr;
        ctr_wdata      = tlbp_pkg::ctr_step(ctr_rd, taken_reg);
        case (state_reg)
            tlbp_pkg::ST_CLEAR:
            begin
                hist_we      = 1'b1;
                hist_waddr   = clr_cnt_reg[INDEX_BITS-1:0];
                hist_wdata   = '0;
                ctr_we       = 1'b1;
                ctr_waddr    = clr_cnt_reg;
                ctr_wdata    = tlbp_pkg::CTR_MIN;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = tlbp_pkg::ST_IDLE;
                end
            end
            tlbp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = tlbp_pkg::ST_HIST;
                end
            end
            tlbp_pkg::ST_HIST:
            begin
                ctr_re     = 1'b1;
                state_next = tlbp_pkg::ST_UPDATE;
            end
            tlbp_pkg::ST_UPDATE:
            begin
                // hold until the previous result has left
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    pred_next      = (ctr_rd >= tlbp_pkg::CTR_TAKEN_MIN);
                    hist_we        = (mode_reg == tlbp_pkg::MODE_UPDATE);
                    ctr_we         = (mode_reg == tlbp_pkg::MODE_UPDATE);
                    state_next     = tlbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlbp_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pred_reg <= pred_next;
        if (accept)
        begin
            mode_reg  <= mode;
            taken_reg <= outcome_taken;
            entry_reg <= in_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_rd_reg <= hist_mem[in_entry];
        end
    end

    tlbp_pattern_table #(
        .SLOT_BITS (SLOT_BITS)
    ) u_pattern_table (
        .clk     (clk),
        .rd_en   (ctr_re),
        .rd_addr (ctr_raddr),
        .rd_ctr  (ctr_rd),
        .wr_en   (ctr_we),
        .wr_addr (ctr_waddr),
        .wr_ctr  (ctr_wdata)
    );

    assign out_valid       = out_valid_reg;
    assign predicted_taken = pred_reg;

    a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == tlbp_pkg::ST_HIST)
        else $error("accepted beat did not start the history read");

    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == tlbp_pkg::ST_UPDATE))
        else $error("result raised outside the update step");

    a_write_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        (ctr_we && state_reg != tlbp_pkg::ST_CLEAR)
            |-> (mode_reg == tlbp_pkg::MODE_UPDATE && state_reg == tlbp_pkg::ST_UPDATE))
        else $error("counter written outside an update beat");

    a_stall_holds_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlbp_pkg::ST_UPDATE && out_valid_reg && !out_ready)
            |=> state_reg == tlbp_pkg::ST_UPDATE)
        else $error("update step left while the output was stalled");

endmodule
`default_nettype wire
